// File: sv/ivd_pkg.sv
`default_nettype none
package ivd_pkg;

  localparam int LANES   = 8;
  localparam int MAX_DIM = 4096;
  localparam int CNT_W   = $clog2(MAX_DIM + 2);

  // metric register codes
  localparam logic [2:0] METRIC_L2    = 3'd0;
  localparam logic [2:0] METRIC_L2SQ  = 3'd1;
  localparam logic [2:0] METRIC_COS   = 3'd2;
  localparam logic [2:0] METRIC_NDOT  = 3'd3;
  localparam logic [2:0] METRIC_L1    = 3'd4;

  // register byte addresses
  localparam logic [2:0] ADDR_METRIC = 3'd0;
  localparam logic [2:0] ADDR_SIGNED = 3'd4;

  localparam logic [63:0] Q16_ONE = 64'd65536;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LANE,
    ST_FINAL,
    ST_MUL,
    ST_ROOT,
    ST_DIV
  } state_t;

  typedef enum logic {
    OP_SQRT,
    OP_DIV
  } op_t;

  typedef struct packed {
    logic go;
    op_t  op;
  } unit_ctrl_t;

  typedef struct packed {
    logic done;
  } unit_stat_t;

  typedef struct packed {
    logic acc_en;
    logic clr;
  } acc_ctrl_t;

  typedef struct packed {
    logic [31:0]      metric_sum;
    logic [31:0]      dot_sum;
    logic [31:0]      norm_a_sum;
    logic [31:0]      norm_b_sum;
    logic [CNT_W-1:0] elem_count;
  } sums_t;

endpackage
`default_nettype wire

// File: sv/ivd_lane_acc.sv
`default_nettype none
module ivd_lane_acc (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ivd_pkg::acc_ctrl_t ctrl,
  input  wire logic [7:0]        a_byte,
  input  wire logic [7:0]        b_byte,
  input  wire logic              elem_signed,
  input  wire logic [2:0]        metric,
  output ivd_pkg::sums_t         sums
);

  logic signed [8:0]  va;
  logic signed [8:0]  vb;
  logic signed [9:0]  d;
  logic signed [17:0] p_ab;
  logic signed [17:0] p_aa;
  logic signed [17:0] p_bb;
  logic signed [19:0] p_dd;
  logic [7:0]         d_abs;
  logic [31:0]        m_add;
  logic               full;

  assign va    = {elem_signed & a_byte[7], a_byte};
  assign vb    = {elem_signed & b_byte[7], b_byte};
  assign d     = {va[8], va} - {vb[8], vb};
  assign p_ab  = va * vb;
  assign p_aa  = va * va;
  assign p_bb  = vb * vb;
  assign p_dd  = d * d;
  assign d_abs = d[9] ? 8'(-d) : d[7:0];
  assign full  = sums.elem_count >= ivd_pkg::CNT_W'(ivd_pkg::MAX_DIM);

  always_comb begin
    case (metric)
      ivd_pkg::METRIC_L2,
      ivd_pkg::METRIC_L2SQ: m_add = {16'd0, p_dd[15:0]};
      ivd_pkg::METRIC_L1:   m_add = {24'd0, d_abs};
      default:              m_add = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      sums <= '0;
    end else if (ctrl.acc_en) begin
      if (full) begin
        // saturate: elements past the limit are dropped
        sums.elem_count <= ivd_pkg::CNT_W'(ivd_pkg::MAX_DIM + 1);
      end else begin
        sums.elem_count <= sums.elem_count + 1'b1;
        sums.dot_sum    <= sums.dot_sum + {{14{p_ab[17]}}, p_ab};
        sums.norm_a_sum <= sums.norm_a_sum + {16'd0, p_aa[15:0]};
        sums.norm_b_sum <= sums.norm_b_sum + {16'd0, p_bb[15:0]};
        sums.metric_sum <= sums.metric_sum + m_add;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/ivd_root_div.sv
`default_nettype none
module ivd_root_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ivd_pkg::unit_ctrl_t ctrl,
  input  wire logic [63:0]         x_in,
  input  wire logic [47:0]         dvd_in,
  input  wire logic [31:0]         dvs_in,
  output ivd_pkg::unit_stat_t      stat,
  output logic [63:0]              result
);

  // One subtract-and-compare, shared by the root and the divide steps.
  // Root: acc is the remainder of x, result the root, bitv the trial bit.
  // Divide: acc the partial remainder, result the quotient, bitv the dividend.
  ivd_pkg::op_t op;
  logic [63:0]  acc;
  logic [63:0]  bitv;
  logic [31:0]  dvs;
  logic [5:0]   cnt;
  logic         running;
  logic [63:0]  sub_a;
  logic [63:0]  sub_b;
  logic [64:0]  diff;
  logic         ge;

  always_comb begin
    if (op == ivd_pkg::OP_SQRT) begin
      sub_a = acc;
      sub_b = result | bitv;
    end else begin
      sub_a = {31'd0, acc[31:0], bitv[47]};
      sub_b = {32'd0, dvs};
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge   = ~diff[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      running   <= 1'b0;
      stat.done <= 1'b0;
      cnt       <= '0;
    end else if (ctrl.go) begin
      running   <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= (ctrl.op == ivd_pkg::OP_SQRT) ? 6'd32 : 6'd48;
    end else if (running) begin
      cnt       <= cnt - 1'b1;
      running   <= cnt != 6'd1;
      stat.done <= cnt == 6'd1;
    end else begin
      stat.done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      op     <= ctrl.op;
      result <= '0;
      dvs    <= dvs_in;
      if (ctrl.op == ivd_pkg::OP_SQRT) begin
        acc  <= x_in;
        bitv <= 64'd1 << 62;
      end else begin
        acc  <= '0;
        bitv <= {16'd0, dvd_in};
      end
    end else if (running) begin
      if (op == ivd_pkg::OP_SQRT) begin
        if (ge) begin
          acc    <= diff[63:0];
          result <= (result >> 1) | bitv;
        end else begin
          result <= result >> 1;
        end
        bitv <= bitv >> 2;
      end else begin
        acc    <= ge ? diff[63:0] : sub_a;
        result <= {result[62:0], ge};
        bitv   <= bitv << 1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/int8_vector_distance.sv
`default_nettype none
// Channel   Handshake            Payload
// ------    ---------            -------
// input     start & !busy        a_bytes, b_bytes, lane_count, last_item
// result    done (one cycle)     distance, dim_overflow
// config    APB psel/penable     paddr, pwdata, prdata (metric @0, elem_signed @4)
//
// An item keeps busy high while its n lane pairs are worked, n being lane_count capped
// at eight: one lane pair goes through the lane accumulator per cycle, then the item
// is closed; a new item is taken only after that, once busy is low again.
// A last item adds the finishing work: L2 holds busy for the closing step, 32 root
// steps and a finishing step; cosine holds it for the closing step, multiply, 32 root
// steps and 48 divide steps, and skips the divide when a norm is zero; the other
// metrics finish in the closing cycle.
// done rises for exactly one cycle; the receiver cannot stall, and busy falls
// in that same cycle so the next item may be taken at once.
// rst is synchronous: sums, counters, config registers and sequencer go to zero.
module int8_vector_distance (
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        start,
  output logic             busy,
  input  wire logic [63:0] a_bytes,
  input  wire logic [63:0] b_bytes,
  input  wire logic [3:0]  lane_count,
  input  wire logic        last_item,
  // results
  output logic             done,
  output logic signed [63:0] distance,
  output logic             dim_overflow,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ivd_pkg::state_t     state;
  ivd_pkg::state_t     state_next;
  ivd_pkg::unit_ctrl_t uctrl;
  ivd_pkg::unit_stat_t ustat;
  ivd_pkg::acc_ctrl_t  actrl;
  ivd_pkg::sums_t      sums;

  logic [2:0]  metric;
  logic        elem_signed;
  logic [63:0] a_sh;
  logic [63:0] b_sh;
  logic [3:0]  lanes_left;
  logic        last_r;
  logic [63:0] prod;
  logic [63:0] root_x;
  logic [63:0] uresult;
  logic        finish;
  logic [63:0] fin_val;
  logic        dot_neg;
  logic [31:0] dot_abs;

  // configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric      <= ivd_pkg::METRIC_L2;
      elem_signed <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr)
        ivd_pkg::ADDR_METRIC: metric      <= pwdata[2:0];
        ivd_pkg::ADDR_SIGNED: elem_signed <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ivd_pkg::ADDR_METRIC: prdata = {29'd0, metric};
      ivd_pkg::ADDR_SIGNED: prdata = {31'd0, elem_signed};
      default:              prdata = 32'd0;
    endcase
  end

  // item capture: lane 0 is loaded into the low byte of the shift registers
  assign busy = state != ivd_pkg::ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      lanes_left <= '0;
      last_r     <= 1'b0;
    end else if (state == ivd_pkg::ST_IDLE && start) begin
      lanes_left <= (lane_count > 4'(ivd_pkg::LANES)) ? 4'(ivd_pkg::LANES) : lane_count;
      last_r     <= last_item;
    end else if (actrl.acc_en) begin
      lanes_left <= lanes_left - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ivd_pkg::ST_IDLE && start) begin
      a_sh <= a_bytes;
      b_sh <= b_bytes;
    end else if (actrl.acc_en) begin
      a_sh <= a_sh >> 8;
      b_sh <= b_sh >> 8;
    end
  end

  // norm product for cosine, taken in the closing cycle
  always_ff @(posedge clk) begin
    if (state == ivd_pkg::ST_FINAL) begin
      prod <= 64'(sums.norm_a_sum) * 64'(sums.norm_b_sum);
    end
  end

  ivd_lane_acc u_acc (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (actrl),
    .a_byte      (a_sh[7:0]),
    .b_byte      (b_sh[7:0]),
    .elem_signed (elem_signed),
    .metric      (metric),
    .sums        (sums)
  );

  assign dot_neg = sums.dot_sum[31];
  assign dot_abs = dot_neg ? -sums.dot_sum : sums.dot_sum;
  assign root_x  = (metric == ivd_pkg::METRIC_COS) ? prod : {sums.metric_sum, 32'd0};

  ivd_root_div u_unit (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (uctrl),
    .x_in   (root_x),
    .dvd_in ({dot_abs, 16'd0}),
    .dvs_in (uresult[31:0]),
    .stat   (ustat),
    .result (uresult)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    case (state)
      ivd_pkg::ST_IDLE:
        if (start) state_next = ivd_pkg::ST_LANE;
      ivd_pkg::ST_LANE:
        if (lanes_left == 4'd0) begin
          state_next = last_r ? ivd_pkg::ST_FINAL : ivd_pkg::ST_IDLE;
        end
      ivd_pkg::ST_FINAL:
        case (metric)
          ivd_pkg::METRIC_L2:  state_next = ivd_pkg::ST_ROOT;
          ivd_pkg::METRIC_COS: state_next = ivd_pkg::ST_MUL;
          default:             state_next = ivd_pkg::ST_IDLE;
        endcase
      ivd_pkg::ST_MUL:
        state_next = ivd_pkg::ST_ROOT;
      ivd_pkg::ST_ROOT:
        if (ustat.done) begin
          state_next = (metric == ivd_pkg::METRIC_COS && uresult != 64'd0)
                       ? ivd_pkg::ST_DIV : ivd_pkg::ST_IDLE;
        end
      ivd_pkg::ST_DIV:
        if (ustat.done) state_next = ivd_pkg::ST_IDLE;
      default:
        state_next = ivd_pkg::ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    uctrl.go     = 1'b0;
    uctrl.op     = ivd_pkg::OP_SQRT;
    actrl.acc_en = 1'b0;
    finish       = 1'b0;
    fin_val      = '0;
    case (state)
      ivd_pkg::ST_LANE:
        actrl.acc_en = lanes_left != 4'd0;
      ivd_pkg::ST_FINAL:
        case (metric)
          ivd_pkg::METRIC_L2:
            uctrl.go = 1'b1;
          ivd_pkg::METRIC_COS: ;
          ivd_pkg::METRIC_L2SQ,
          ivd_pkg::METRIC_L1: begin
            finish  = 1'b1;
            fin_val = {16'd0, sums.metric_sum, 16'd0};
          end
          ivd_pkg::METRIC_NDOT: begin
            finish  = 1'b1;
            fin_val = -{{16{sums.dot_sum[31]}}, sums.dot_sum, 16'd0};
          end
          default: begin
            // unused metric code reads as zero
            finish  = 1'b1;
            fin_val = '0;
          end
        endcase
      ivd_pkg::ST_MUL:
        uctrl.go = 1'b1;
      ivd_pkg::ST_ROOT:
        if (ustat.done) begin
          if (metric != ivd_pkg::METRIC_COS) begin
            finish  = 1'b1;
            fin_val = uresult;
          end else if (uresult == 64'd0) begin
            // a zero norm gives distance 1.0
            finish  = 1'b1;
            fin_val = ivd_pkg::Q16_ONE;
          end else begin
            uctrl.go = 1'b1;
            uctrl.op = ivd_pkg::OP_DIV;
          end
        end
      ivd_pkg::ST_DIV:
        if (ustat.done) begin
          finish  = 1'b1;
          fin_val = dot_neg ? ivd_pkg::Q16_ONE + uresult : ivd_pkg::Q16_ONE - uresult;
        end
      default: ;
    endcase
  end

  // sums clear in the same edge that loads the result
  assign actrl.clr = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ivd_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      distance     <= fin_val;
      dim_overflow <= sums.elem_count > ivd_pkg::CNT_W'(ivd_pkg::MAX_DIM);
    end
  end

endmodule
`default_nettype wire
